[src/att_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// att_pkg
// Shared constants and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package att_pkg;
	localparam int COLUMNS_DEF = 64;
	localparam int ROWS_DEF    = 36;

	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_BS   = 8'h08;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_ESC  = 8'h1B;
	localparam logic [7:0] CH_LBR  = 8'h5B;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_TWO  = 8'h32;
	localparam logic [7:0] CH_A    = 8'h41;
	localparam logic [7:0] CH_B    = 8'h42;
	localparam logic [7:0] CH_C    = 8'h43;
	localparam logic [7:0] CH_D    = 8'h44;
	localparam logic [7:0] CH_H    = 8'h48;
	localparam logic [7:0] CH_J    = 8'h4A;

	localparam logic [2:0] ESC_NONE = 3'd0;
	localparam logic [2:0] ESC_SEEN = 3'd1;
	localparam logic [2:0] ESC_CSI  = 3'd2;
	localparam logic [2:0] ESC_NUM1 = 3'd3;
	localparam logic [2:0] ESC_SEMI = 3'd4;
	localparam logic [2:0] ESC_NUM2 = 3'd5;

	// datapath memory operation selected by the controller
	localparam logic [1:0] MOP_NONE  = 2'd0;
	localparam logic [1:0] MOP_READ  = 2'd1;
	localparam logic [1:0] MOP_WRITE = 2'd2;
	localparam logic [1:0] MOP_COPY  = 2'd3;

	typedef struct packed {
		logic [1:0] mop;
		logic       wr_zero;
		logic       use_sweep;
		logic       sweep_clr;
		logic       sweep_inc;
	} dp_cmd_t;

	typedef struct packed {
		logic sweep_last;
	} dp_sts_t;
endpackage

[src/att_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// att_datapath
// Character store, read data register and sweep address counter.
// ----------------------------------------------------------------------------
module att_datapath import att_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF,
	parameter int AW      = $clog2(COLUMNS * ROWS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  dp_cmd_t       cmd,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] sweep_end,
	output dp_sts_t       sts,
	output logic [7:0]    rdata
);
	localparam int CELLS = COLUMNS * ROWS;

	logic [7:0]    mem [CELLS];
	logic [AW-1:0] sweep_q;
	logic [AW-1:0] copy_src;
	logic [AW-1:0] waddr;

	assign copy_src = AW'(sweep_q + AW'(COLUMNS));
	assign waddr    = cmd.use_sweep ? sweep_q : addr;
	assign sts.sweep_last = (sweep_q == sweep_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep_clr) begin
			sweep_q <= '0;
		end else if (cmd.sweep_inc) begin
			sweep_q <= AW'(sweep_q + 1'b1);
		end
	end

	// copy reads a cell of the row below and writes it in the next cycle
	logic [AW-1:0] cp_dst_q;
	logic          cp_pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_pend_q <= 1'b0;
		end else begin
			cp_pend_q <= (cmd.mop == MOP_COPY);
		end
	end

	always_ff @(posedge clk) begin
		cp_dst_q <= sweep_q;
		if (cmd.mop == MOP_COPY) begin
			rdata <= mem[copy_src];
		end else if (cmd.mop == MOP_READ) begin
			rdata <= mem[addr];
		end
		if (cp_pend_q) begin
			mem[cp_dst_q] <= rdata;
		end else if (cmd.mop == MOP_WRITE) begin
			mem[waddr] <= cmd.wr_zero ? 8'h00 : wdata;
		end
	end
endmodule

[src/att_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// att_ctrl
// Handshake, escape parser, cursor and sequencing of clear and scroll sweeps.
// ----------------------------------------------------------------------------
module att_ctrl import att_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF,
	parameter int AW      = $clog2(COLUMNS * ROWS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          req_type,
	input  logic [7:0]    char_in,
	input  logic [11:0]   cell_addr,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    cell_char,
	output logic [11:0]   cursor_now,
	output dp_cmd_t       cmd,
	output logic [AW-1:0] addr,
	output logic [7:0]    wdata,
	output logic [AW-1:0] sweep_end,
	input  dp_sts_t       sts,
	input  logic [7:0]    rdata
);
	localparam int CELLS = COLUMNS * ROWS;
	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RDWT  = 3'd1;
	localparam logic [2:0] ST_CLEAR = 3'd2;
	localparam logic [2:0] ST_COPY  = 3'd3;
	localparam logic [2:0] ST_BLANK = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;
	localparam logic [2:0] ST_CPEND = 3'd6;
	localparam logic [2:0] ST_INIT  = 3'd7;

	logic [2:0]  state_q;
	logic [2:0]  mode_q;
	logic [7:0]  rown_q, coln_q;
	logic [1:0]  fdc_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic        rd_pend_q, rd_zero_q;

	logic        accept, out_free;
	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign accept   = in_valid && in_ready;

	// decode
	logic is_digit, is_dir, bad_seq, do_clear, do_print;
	logic [7:0] dig_val, acc;
	logic [2:0] mode_n;
	logic [7:0] rown_n, coln_n;
	logic [1:0] fdc_n;
	logic [CW-1:0] col_n;
	logic [RW:0]   row_n;
	logic [AW:0]   lin;
	logic [11:0]   add10;

	assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
	assign is_dir   = (char_in >= CH_A && char_in <= CH_D) || char_in == CH_H;
	assign dig_val  = char_in - CH_ZERO;

	always_comb begin
		logic plain;
		logic [7:0] rr, kk;
		acc = (mode_q == ESC_NUM1 || mode_q == ESC_CSI) ? rown_q : coln_q;
		add10 = 12'(acc) * 12'd10 + 12'(dig_val);
		mode_n = mode_q; rown_n = rown_q; coln_n = coln_q; fdc_n = fdc_q;
		col_n = col_q; row_n = {1'b0, row_q};
		plain = 1'b0; do_clear = 1'b0; do_print = 1'b0; bad_seq = 1'b0;
		lin = '0;
		rr = '0; kk = '0;
		if (char_in == CH_ESC) begin
			mode_n = ESC_SEEN; rown_n = '0; coln_n = '0; fdc_n = '0;
		end else if (char_in == CH_LBR) begin
			if (mode_q == ESC_SEEN) mode_n = ESC_CSI;
			else plain = 1'b1;
		end else if (is_dir) begin
			if (mode_q == ESC_CSI) begin
				case (char_in)
					CH_A: row_n = (row_q != '0) ? {1'b0, row_q} - 1'b1 : '0;
					CH_B: row_n = {1'b0, row_q} + 1'b1;
					CH_C: begin
						col_n = CW'(col_q + 1'b1);
						if (col_q == CW'(COLUMNS - 1)) row_n = {1'b0, row_q} + 1'b1;
					end
					CH_D: begin
						if (col_q != '0) col_n = col_q - 1'b1;
						else if (row_q != '0) begin
							col_n = CW'(COLUMNS - 1); row_n = {1'b0, row_q} - 1'b1;
						end
					end
					default: begin col_n = '0; row_n = '0; end
				endcase
				if (char_in == CH_A && row_q == '0) col_n = '0;
				mode_n = ESC_NONE; rown_n = '0; coln_n = '0; fdc_n = '0;
			end else if (mode_q == ESC_NUM2 && char_in == CH_H) begin
				rr = (rown_q > 8'(ROWS - 1)) ? 8'(ROWS - 1) : rown_q;
				kk = (coln_q > 8'(COLUMNS - 1)) ? 8'(COLUMNS - 1) : coln_q;
				row_n = (RW + 1)'(rr); col_n = CW'(kk);
				mode_n = ESC_NONE; rown_n = '0; coln_n = '0; fdc_n = '0;
			end else plain = 1'b1;
		end else if (mode_q == ESC_NUM1 && fdc_q == 2'd1 && rown_q == 8'd2
				&& char_in == CH_J) begin
			do_clear = 1'b1;
			mode_n = ESC_NONE; rown_n = '0; coln_n = '0; fdc_n = '0;
		end else if (is_digit) begin
			if (mode_q == ESC_CSI || mode_q == ESC_NUM1) begin
				rown_n = (add10 > 12'd255) ? 8'd255 : add10[7:0];
				if (fdc_q != 2'd3) fdc_n = fdc_q + 1'b1;
				mode_n = ESC_NUM1;
			end else if (mode_q == ESC_SEMI || mode_q == ESC_NUM2) begin
				coln_n = (add10 > 12'd255) ? 8'd255 : add10[7:0];
				mode_n = ESC_NUM2;
			end else plain = 1'b1;
		end else if (char_in == CH_SEMI) begin
			if (mode_q == ESC_NUM1) mode_n = ESC_SEMI;
			else plain = 1'b1;
		end else plain = 1'b1;

		if (plain) begin
			mode_n = ESC_NONE; rown_n = '0; coln_n = '0; fdc_n = '0;
			case (char_in)
				CH_BS: begin
					if (col_q != '0) col_n = col_q - 1'b1;
					else if (row_q != '0) begin
						col_n = CW'(COLUMNS - 1); row_n = {1'b0, row_q} - 1'b1;
					end
				end
				CH_CR: col_n = '0;
				CH_LF: begin col_n = '0; row_n = {1'b0, row_q} + 1'b1; end
				CH_NUL: ;
				default: begin
					do_print = 1'b1;
					col_n = CW'(col_q + 1'b1);
					if (col_q == CW'(COLUMNS - 1)) row_n = {1'b0, row_q} + 1'b1;
				end
			endcase
		end
		bad_seq = (row_n >= (RW + 1)'(ROWS));
		if (bad_seq) row_n = row_n - 1'b1;
		lin = (AW + 1)'(row_q) * (AW + 1)'(COLUMNS) + (AW + 1)'(col_q);
	end

	logic scroll_n;
	assign scroll_n = bad_seq;

	logic [AW:0] cur_lin;
	assign cur_lin = (AW + 1)'(row_q) * (AW + 1)'(COLUMNS) + (AW + 1)'(col_q);
	assign cursor_now = 12'(cur_lin);

	logic [7:0] cell_q;
	assign cell_char = rd_pend_q ? (rd_zero_q ? 8'h00 : rdata) : cell_q;

	logic out_set;
	assign out_set = (accept && (req_type || !(do_clear || scroll_n)))
		|| (state_q == ST_DONE);

	always_comb begin
		cmd = '0;
		addr = AW'(lin);
		wdata = char_in;
		sweep_end = AW'(CELLS - 1);
		if (accept && !req_type && do_print) cmd.mop = MOP_WRITE;
		if (accept && req_type && cell_addr < 12'(CELLS)) begin
			cmd.mop = MOP_READ; addr = AW'(cell_addr);
		end
		if (accept && (do_clear || (!req_type && scroll_n))) cmd.sweep_clr = 1'b1;
		case (state_q)
			ST_INIT, ST_CLEAR: begin
				cmd.mop = MOP_WRITE; cmd.wr_zero = 1'b1; cmd.use_sweep = 1'b1;
				cmd.sweep_inc = 1'b1;
			end
			ST_COPY: begin
				sweep_end = AW'(CELLS - COLUMNS - 1);
				cmd.mop = MOP_COPY; cmd.sweep_inc = 1'b1;
			end
			ST_BLANK: begin
				cmd.mop = MOP_WRITE; cmd.wr_zero = 1'b1; cmd.use_sweep = 1'b1;
				cmd.sweep_inc = 1'b1;
			end
			default: ;
		endcase
		if (state_q == ST_COPY) sweep_end = AW'(CELLS - COLUMNS - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT; mode_q <= ESC_NONE;
			rown_q <= '0; coln_q <= '0; fdc_q <= '0;
			col_q <= '0; row_q <= '0;
			out_valid <= 1'b0; rd_pend_q <= 1'b0; rd_zero_q <= 1'b0;
			cell_q <= '0;
		end else begin
			if (out_set) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			rd_pend_q <= accept && req_type;
			if (accept && req_type) rd_zero_q <= !(cell_addr < 12'(CELLS));
			if (accept && !req_type) begin
				cell_q <= 8'h00;
			end else if (rd_pend_q) begin
				cell_q <= rd_zero_q ? 8'h00 : rdata;
			end
			case (state_q)
				ST_INIT: if (sts.sweep_last) state_q <= ST_IDLE;
				ST_IDLE: begin
					if (accept && !req_type) begin
						mode_q <= mode_n; rown_q <= rown_n; coln_q <= coln_n;
						fdc_q <= fdc_n; col_q <= col_n; row_q <= RW'(row_n);
						if (do_clear) state_q <= ST_CLEAR;
						else if (scroll_n) state_q <= ST_COPY;
					end
				end
				ST_CLEAR: if (sts.sweep_last) state_q <= ST_DONE;
				ST_COPY: if (sts.sweep_last) state_q <= ST_CPEND;
				ST_CPEND: state_q <= ST_BLANK;
				ST_BLANK: if (sts.sweep_last) state_q <= ST_DONE;
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("input taken during sweep");
	assert property (@(posedge clk) disable iff (!arst_n)
		cur_lin < (AW + 1)'(CELLS))
		else $error("cursor off screen");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> out_valid)
		else $error("sweep finished without result");
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type) |=> (out_valid && state_q == ST_IDLE))
		else $error("read result missing");
endmodule

[src/ansi_text_terminal.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_text_terminal
// Character-cell terminal with escape sequence parsing and scrolling.
//
// channel | handshake             | payload
// in      | in_valid / in_ready   | req_type, char_in, cell_addr
// out     | out_valid / out_ready | cell_char, cursor_now
//
// A read or an ordinary write is taken when in_valid and in_ready are high; its result is valid the next cycle.
// A clear zeroes one cell per cycle and then passes through the done state to its result.
// A scroll copies COLUMNS*(ROWS-1) cells, lets the last copy land in a pending state and
// blanks COLUMNS cells; it then passes through the done state to its result.
// After reset a clearing pass zeroes every cell of the store before input opens.
// Input is held off during those walks and while a result waits.
// ----------------------------------------------------------------------------
module ansi_text_terminal import att_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  char_in,
	input  logic [11:0] cell_addr,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  cell_char,
	output logic [11:0] cursor_now
);
	localparam int AW = $clog2(COLUMNS * ROWS);

	dp_cmd_t       cmd;
	dp_sts_t       sts;
	logic [AW-1:0] addr, sweep_end;
	logic [7:0]    wdata, rdata;

	att_ctrl #(.COLUMNS(COLUMNS), .ROWS(ROWS), .AW(AW)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .req_type, .char_in, .cell_addr,
		.out_valid, .out_ready, .cell_char, .cursor_now,
		.cmd, .addr, .wdata, .sweep_end, .sts, .rdata
	);

	att_datapath #(.COLUMNS(COLUMNS), .ROWS(ROWS), .AW(AW)) u_dp (
		.clk, .arst_n, .cmd, .addr, .wdata, .sweep_end, .sts, .rdata
	);
endmodule

[bench/tb_ansi_text_terminal.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ansi_text_terminal
// Self-checking bench for the escape-parsing text terminal.
//
// A character-stream predictor keeps its own copy of the screen, cursor and
// sequence parser. Each accepted transaction queues one expected cell/cursor
// pair, and each accepted result is compared with the oldest one. Stimulus is
// a directed pass over the control bytes, escape forms and edge addresses,
// followed by random text, escape sequences (well formed and broken) and
// screen reads. Random idling and stalls are applied on both sides.
// ----------------------------------------------------------------------------
module tb_ansi_text_terminal import att_pkg::*; ();

	localparam int COLS  = COLUMNS_DEF;
	localparam int LINES = ROWS_DEF;
	localparam int CELLS = COLS * LINES;
	localparam int NUM_ITEMS = 1150;
	localparam int QUIET_ITEMS = 150;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int LONG_HOLD = 300;
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	class terminal_scoreboard;
		typedef struct {
			logic [7:0]  char_val;
			logic [11:0] cursor;
		} screen_result_t;

		logic [7:0]     screen [CELLS];
		int             cursor;
		logic [2:0]     parse_mode;
		int             row_val;
		int             col_val;
		int             row_digits;
		screen_result_t expected_q[$];
		int             errors;

		function void clear_all();
			foreach (screen[i]) screen[i] = 8'h00;
			cursor = 0;
			errors = 0;
			drop_sequence();
		endfunction

		function void drop_sequence();
			parse_mode = ESC_NONE;
			row_val = 0;
			col_val = 0;
			row_digits = 0;
		endfunction

		function int accumulate(int acc, int d);
			int v;
			v = acc * 10 + d;
			return (v > 255) ? 255 : v;
		endfunction

		function void plain_char(logic [7:0] c);
			drop_sequence();
			if (c == CH_BS) begin
				if (cursor > 0) cursor--;
			end else if (c == CH_CR) begin
				cursor -= cursor % COLS;
			end else if (c == CH_LF) begin
				cursor += COLS;
				cursor -= cursor % COLS;
			end else if (c != CH_NUL) begin
				if (cursor < CELLS) screen[cursor] = c;
				cursor++;
			end
		endfunction

		function void feed_char(logic [7:0] c);
			int r;
			int k;
			if (c == CH_ESC) begin
				drop_sequence();
				parse_mode = ESC_SEEN;
			end else if (c == CH_LBR) begin
				if (parse_mode == ESC_SEEN) parse_mode = ESC_CSI;
				else plain_char(c);
			end else if ((c >= CH_A && c <= CH_D) || c == CH_H) begin
				if (parse_mode == ESC_CSI) begin
					case (c)
						CH_A: cursor = (cursor >= COLS) ? cursor - COLS : 0;
						CH_B: cursor += COLS;
						CH_C: cursor += 1;
						CH_D: cursor = (cursor > 0) ? cursor - 1 : 0;
						default: cursor = 0;
					endcase
					drop_sequence();
				end else if (parse_mode == ESC_NUM2 && c == CH_H) begin
					r = (row_val > LINES - 1) ? LINES - 1 : row_val;
					k = (col_val > COLS - 1) ? COLS - 1 : col_val;
					cursor = r * COLS + k;
					drop_sequence();
				end else begin
					plain_char(c);
				end
			end else if (parse_mode == ESC_NUM1 && row_digits == 1 && row_val == 2 &&
					c == CH_J) begin
				foreach (screen[i]) screen[i] = 8'h00;
				drop_sequence();
			end else if (c >= CH_ZERO && c <= CH_NINE) begin
				if (parse_mode == ESC_CSI || parse_mode == ESC_NUM1) begin
					row_val = accumulate(row_val, c - CH_ZERO);
					if (row_digits < 3) row_digits++;
					parse_mode = ESC_NUM1;
				end else if (parse_mode == ESC_SEMI || parse_mode == ESC_NUM2) begin
					col_val = accumulate(col_val, c - CH_ZERO);
					parse_mode = ESC_NUM2;
				end else begin
					plain_char(c);
				end
			end else if (c == CH_SEMI) begin
				if (parse_mode == ESC_NUM1) parse_mode = ESC_SEMI;
				else plain_char(c);
			end else begin
				plain_char(c);
			end
			if (cursor / COLS >= LINES) begin
				for (int i = 0; i < COLS * (LINES - 1); i++) screen[i] = screen[i + COLS];
				for (int i = COLS * (LINES - 1); i < CELLS; i++) screen[i] = 8'h00;
				cursor -= COLS;
			end
		endfunction

		function void note_transaction(logic kind, logic [7:0] c, logic [11:0] addr);
			screen_result_t res;
			res.char_val = 8'h00;
			if (kind == REQ_WRITE) feed_char(c);
			else if (addr < CELLS) res.char_val = screen[addr];
			res.cursor = cursor[11:0];
			expected_q.insert(expected_q.size(), res);
		endfunction

		function void check_result(logic [7:0] cell_val, logic [11:0] cur);
			screen_result_t res;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result cell=%h cursor=%0d", $time, cell_val, cur);
				errors++;
				return;
			end
			res = expected_q[0];
			expected_q.delete(0);
			if (cell_val !== res.char_val) begin
				$display("%0t: cell_char expected %h actual %h", $time, res.char_val,
					cell_val);
				errors++;
			end
			if (cur !== res.cursor) begin
				$display("%0t: cursor_now expected %0d actual %0d", $time, res.cursor, cur);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        req_type;
	logic [7:0]  char_in;
	logic [11:0] cell_addr;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  cell_char;
	logic [11:0] cursor_now;

	terminal_scoreboard sb;
	bit idle_on;
	int long_hold_req;
	int items_sent;
	int quiet_cycles;

	ansi_text_terminal dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .char_in(char_in), .cell_addr(cell_addr),
		.out_valid(out_valid), .out_ready(out_ready),
		.cell_char(cell_char), .cursor_now(cursor_now)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic send_item(logic kind, logic [7:0] c, logic [11:0] addr);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		char_in <= c;
		cell_addr <= addr;
		do @(posedge clk); while (!in_ready);
		sb.note_transaction(kind, c, addr);
		items_sent++;
	endtask

	task automatic write_char(logic [7:0] c);
		send_item(REQ_WRITE, c, 12'($urandom_range(0, 4095)));
	endtask

	task automatic write_text(string s);
		for (int i = 0; i < s.len(); i++) write_char(s[i]);
	endtask

	task automatic read_cell(logic [11:0] addr);
		send_item(REQ_READ, 8'($urandom), addr);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic random_sequence();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 28) begin
			if ($urandom_range(0, 3) == 0) read_cell(12'($urandom_range(0, 4095)));
			else read_cell(12'($urandom_range(0, CELLS - 1)));
		end else if (pick < 55) begin
			n = $urandom_range(1, 8);
			repeat (n) write_char(8'($urandom_range(8'h20, 8'h7E)));
		end else if (pick < 62) begin
			write_char(8'($urandom));
		end else if (pick < 65) begin
			write_char(CH_LF);
		end else if (pick < 69) begin
			case ($urandom_range(0, 3))
				0: write_char(CH_CR);
				1: write_char(CH_BS);
				2: write_char(CH_NUL);
				default: write_char(CH_LF);
			endcase
		end else if (pick < 79) begin
			write_text("\033[");
			case ($urandom_range(0, 4))
				0: write_char(CH_A);
				1: write_char(CH_B);
				2: write_char(CH_C);
				3: write_char(CH_D);
				default: write_char(CH_H);
			endcase
		end else if (pick < 90) begin
			write_text("\033[");
			write_text($sformatf("%0d;%0d", $urandom_range(0, 40), $urandom_range(0, 70)));
			write_char(CH_H);
		end else if (pick < 92) begin
			if ($urandom_range(0, 2) == 0) write_text("\033[");
			else write_text("\033[2J");
			if ($urandom_range(0, 2) != 0) write_char(CH_J);
		end else begin
			write_char(CH_ESC);
			n = $urandom_range(0, 4);
			repeat (n) begin
				case ($urandom_range(0, 4))
					0: write_char(CH_LBR);
					1: write_char(CH_SEMI);
					2: write_char(8'($urandom_range(CH_ZERO, CH_NINE)));
					3: write_char(CH_ESC);
					default: write_char(8'($urandom));
				endcase
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : receiver
		int hold_left;
		int stall_left;
		hold_left = 0;
		stall_left = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) sb.check_result(cell_char, cursor_now);
			if (long_hold_req != 0) begin
				hold_left = long_hold_req;
				long_hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 9) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		sb = new();
		sb.clear_all();
		idle_on = 1'b1;
		long_hold_req = 0;
		items_sent = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_WRITE;
		char_in = 8'h00;
		cell_addr = 12'h000;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		read_cell(12'd0);
		read_cell(12'(CELLS - 1));
		read_cell(12'hFFF);
		write_char(8'hFF);
		write_char(8'h20);
		write_char(CH_NUL);
		write_char(CH_BS);
		write_char(CH_CR);
		write_char(CH_BS);
		write_text("\033[A\033[D\033[B\033[C\033[H");
		write_text("\033[5A\033[7;9H\033[999;999H");
		write_char(CH_LF);
		read_cell(12'(CELLS - COLS - 1));
		write_text("\033[2J");
		read_cell(12'(CELLS - 2));
		write_text("\033[22J\033[5;H\033x[;");

		drain_results();
		long_hold_req = LONG_HOLD;
		repeat (10) write_char(8'($urandom_range(8'h21, 8'h7E)));
		drain_results();

		while (items_sent < NUM_ITEMS) begin
			if (items_sent >= NUM_ITEMS - QUIET_ITEMS) idle_on = 1'b0;
			random_sequence();
		end
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
